// File: hdl/cnv_pkg.sv
// Shared types and constants of the 3x3 valid convolution block.
// No dependencies; every other file refers to this package by scoped names.
package cnv_pkg;

    localparam int DATA_W          = 32;
    localparam int TAPS            = 9;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS        = 4096;
    localparam int COLS_W          = 7;
    localparam int ROW_W           = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLUMNS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 3'd6;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [TAPS-1:0][DATA_W-1:0] coef_t;

    typedef struct packed {
        logic [COLS_W-1:0] cols;
        logic [ROW_W-1:0]  rows;
    } geom_t;

    // One complete 3x3 window, taps in coefficient order.
    typedef struct packed {
        logic [TAPS-1:0][DATA_W-1:0] taps;
        logic                        last;
    } window_t;

endpackage

// File: hdl/conv2d_3x3_valid_int32.sv
// Streaming valid 3x3 convolution of signed 32-bit samples over a pre-padded image.
// Throughput: one sample per cycle when the output does not stall; at most one
// transaction on each side per cycle. A sample that completes a window reaches the
// output through the window, queue, product, partial-sum and final-sum registers.
// Reset (rst_n, asynchronous, active low) clears the position counters, the window,
// all handshake state and the registers; the line stores hold garbage until written.
module conv2d_3x3_valid_int32 #(
    parameter int MAX_COLUMNS = cnv_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [31:0] sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [31:0] pixel_out
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    cnv_pkg::coef_t   coef_reg;
    cnv_pkg::geom_t   geom_reg;
    cnv_pkg::window_t front_item;
    cnv_pkg::window_t queue_item;

    logic front_valid;
    logic front_ready;
    logic queue_valid;
    logic queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg      <= '0;
            geom_reg.cols <= cnv_pkg::COLS_W'(64);
            geom_reg.rows <= cnv_pkg::ROW_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cnv_pkg::REG_COEF_PAIR_0:
                begin
                    coef_reg[0] <= cfg_data[31:0];
                    coef_reg[1] <= cfg_data[63:32];
                end
                cnv_pkg::REG_COEF_PAIR_1:
                begin
                    coef_reg[2] <= cfg_data[31:0];
                    coef_reg[3] <= cfg_data[63:32];
                end
                cnv_pkg::REG_COEF_PAIR_2:
                begin
                    coef_reg[4] <= cfg_data[31:0];
                    coef_reg[5] <= cfg_data[63:32];
                end
                cnv_pkg::REG_COEF_PAIR_3:
                begin
                    coef_reg[6] <= cfg_data[31:0];
                    coef_reg[7] <= cfg_data[63:32];
                end
                cnv_pkg::REG_COEF_LAST:
                begin
                    coef_reg[8] <= cfg_data[31:0];
                end
                cnv_pkg::REG_OUT_COLUMNS:
                begin
                    geom_reg.cols <= cfg_data[cnv_pkg::COLS_W-1:0];
                end
                cnv_pkg::REG_OUT_ROWS:
                begin
                    geom_reg.rows <= cfg_data[cnv_pkg::ROW_W-1:0];
                end
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    cnv_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .geom      (geom_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    cnv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    cnv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_item   (queue_item),
        .coef      (coef_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: hdl/cnv_front.sv
// Front end: takes samples, tracks the image position, keeps the two line stores
// and the window registers, and hands complete windows on. Uses cnv_pkg.
module cnv_front #(
    parameter int MAX_COLUMNS = cnv_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cnv_pkg::DATA_W-1:0]    in_sample,
    input  cnv_pkg::geom_t                geom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cnv_pkg::window_t              out_item
);

    localparam int DEPTH = MAX_COLUMNS + 2;
    localparam int CNT_W = $clog2(DEPTH);

    logic [cnv_pkg::DATA_W-1:0] mem_upper [DEPTH];
    logic [cnv_pkg::DATA_W-1:0] mem_lower [DEPTH];

    logic [CNT_W-1:0]          col_reg;
    logic [cnv_pkg::ROW_W-1:0] row_reg;

    logic                       s1_valid_reg;
    logic                       s1_out_reg;
    logic                       s1_last_reg;
    logic [CNT_W-1:0]           s1_col_reg;
    logic [cnv_pkg::DATA_W-1:0] s1_sample_reg;
    logic [cnv_pkg::DATA_W-1:0] rd_upper_reg;
    logic [cnv_pkg::DATA_W-1:0] rd_lower_reg;
    logic [cnv_pkg::DATA_W-1:0] win_reg [6];

    logic [CNT_W-1:0]          col_end;
    logic [cnv_pkg::ROW_W-1:0] row_end;
    logic                      at_col_end;
    logic                      at_row_end;
    logic                      accept;
    logic                      s1_fire;

    // Last column and row index of the padded input, with the width and height clamped.
    always_comb
    begin
        if (geom.cols == '0)
            col_end = CNT_W'(2);
        else if (32'(geom.cols) > 32'(MAX_COLUMNS))
            col_end = CNT_W'(MAX_COLUMNS + 1);
        else
            col_end = CNT_W'(32'(geom.cols) + 32'd1);

        if (geom.rows == '0)
            row_end = cnv_pkg::ROW_W'(2);
        else if (32'(geom.rows) > 32'(cnv_pkg::MAX_ROWS))
            row_end = cnv_pkg::ROW_W'(cnv_pkg::MAX_ROWS + 1);
        else
            row_end = cnv_pkg::ROW_W'(32'(geom.rows) + 32'd1);
    end

    assign at_col_end = (col_reg >= col_end);
    assign at_row_end = (row_reg >= row_end);

    assign s1_fire  = s1_valid_reg && (!s1_out_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    assign out_valid = s1_valid_reg && s1_out_reg;

    always_comb
    begin
        out_item.taps[0] = win_reg[0];
        out_item.taps[1] = win_reg[1];
        out_item.taps[2] = rd_upper_reg;
        out_item.taps[3] = win_reg[2];
        out_item.taps[4] = win_reg[3];
        out_item.taps[5] = rd_lower_reg;
        out_item.taps[6] = win_reg[4];
        out_item.taps[7] = win_reg[5];
        out_item.taps[8] = s1_sample_reg;
        out_item.last    = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_out_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_out_reg <= (row_reg >= cnv_pkg::ROW_W'(2)) && (col_reg >= CNT_W'(2));
                if (at_col_end)
                begin
                    col_reg <= '0;
                    row_reg <= at_row_end ? '0 : row_reg + cnv_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CNT_W'(1);
                end
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= rd_upper_reg;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= rd_lower_reg;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= s1_sample_reg;
            end
        end
    end

    // The read for the next sample never meets the write of the one in flight:
    // neighboring columns always differ.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= in_sample;
            s1_col_reg    <= col_reg;
            s1_last_reg   <= at_col_end && at_row_end;
            rd_upper_reg  <= mem_upper[col_reg];
            rd_lower_reg  <= mem_lower[col_reg];
        end
        if (s1_fire)
        begin
            mem_upper[s1_col_reg] <= rd_lower_reg;
            mem_lower[s1_col_reg] <= s1_sample_reg;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample did not reach the window stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stalled window stage lost its sample");
`endif

endmodule

// File: hdl/cnv_queue.sv
// Short queue of complete windows between the front end and the arithmetic.
// Uses cnv_pkg for the window type and the depth.
module cnv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cnv_pkg::window_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output cnv_pkg::window_t out_item
);

    localparam int DEPTH = cnv_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    cnv_pkg::window_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != (PTR_W + 1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = store[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= in_item;
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W + 1)'(DEPTH))
        else $error("window queue holds more than its depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + (PTR_W + 1)'(1)))
        else $error("window queue miscounted a push");
`endif

endmodule

// File: hdl/cnv_back.sv
// Arithmetic back end: nine products, three partial sums, one final sum, each
// registered, with an elastic handshake per stage. Uses cnv_pkg.
module cnv_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cnv_pkg::window_t           in_item,
    input  cnv_pkg::coef_t             coef,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cnv_pkg::DATA_W-1:0] out_pixel,
    output logic                       out_last
);

    logic                       a_valid_reg;
    logic                       a_last_reg;
    logic [cnv_pkg::DATA_W-1:0] a_prod_reg [cnv_pkg::TAPS];

    logic                       b_valid_reg;
    logic                       b_last_reg;
    logic [cnv_pkg::DATA_W-1:0] b_part_reg [3];

    logic                       c_valid_reg;
    logic                       c_last_reg;
    logic [cnv_pkg::DATA_W-1:0] c_sum_reg;

    logic a_ready;
    logic b_ready;
    logic c_ready;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign out_valid = c_valid_reg;
    assign out_pixel = c_sum_reg;
    assign out_last  = c_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Only the low 32 bits of each product matter: the sum wraps modulo 2^32.
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_last_reg <= in_item.last;
            for (int i = 0; i < cnv_pkg::TAPS; i++)
            begin
                a_prod_reg[i] <= in_item.taps[i] * coef[i];
            end
        end
        if (b_ready && a_valid_reg)
        begin
            b_last_reg <= a_last_reg;
            for (int k = 0; k < 3; k++)
            begin
                b_part_reg[k] <= a_prod_reg[3*k] + a_prod_reg[3*k+1] + a_prod_reg[3*k+2];
            end
        end
        if (c_ready && b_valid_reg)
        begin
            c_last_reg <= b_last_reg;
            c_sum_reg  <= b_part_reg[0] + b_part_reg[1] + b_part_reg[2];
        end
    end

`ifndef SYNTHESIS
    a_prod_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_ready) |=> b_valid_reg)
        else $error("product stage advanced into nothing");

    a_part_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && c_ready) |=> c_valid_reg)
        else $error("partial-sum stage advanced into nothing");
`endif

endmodule
